[rtl/f64rem_pkg.sv]
// Package for the binary64 truncated remainder unit.
// Holds controller command/status structs and binary64 constants; no dependencies.
package f64rem_pkg;

  localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] EXP_ALL     = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture operands and classify
    logic norm;      // one normalization step on both significands
    logic step;      // one shift-subtract iteration
    logic fin;       // final subtract
    logic rnorm;     // one left-normalize step of the remainder
    logic pack;      // form the result word
  } f64rem_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic special;   // result already fixed by a special case
    logic norm_done; // both significands have bit 52 set
    logic loop_done; // exponent of x reached that of y, or remainder zero
    logic rnorm_done;// remainder normalized or zero
  } f64rem_sts_t;

endpackage

[rtl/f64rem_ctrl.sv]
// Controller for the binary64 truncated remainder unit.
// Sequences load, classify, normalize, shift-subtract, final subtract, remainder normalize and pack; uses f64rem_pkg.
module f64rem_ctrl import f64rem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  f64rem_sts_t sts,
  output f64rem_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLASS = 7'b0000010,
    S_NORM  = 7'b0000100,
    S_LOOP  = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_RNORM = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Decode state into datapath commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        if (sts.special) state_nxt = S_OUT;
        else state_nxt = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_done) state_nxt = S_LOOP;
        else cmd.norm = 1'b1;
      end
      S_LOOP: begin
        if (sts.loop_done) state_nxt = S_FIN;
        else cmd.step = 1'b1;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_RNORM;
      end
      S_RNORM: begin
        if (sts.rnorm_done) begin
          cmd.pack  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.rnorm = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

[rtl/f64rem_dp.sv]
// Datapath for the binary64 truncated remainder unit.
// Operand registers, shift-subtract loop and result packing; uses f64rem_pkg.
module f64rem_dp import f64rem_pkg::*; (
  input  logic        clk,
  input  logic [63:0] in_dividend_bits,
  input  logic [63:0] in_divisor_bits,
  input  f64rem_cmd_t cmd,
  output f64rem_sts_t sts,
  output logic [63:0] out_remainder_bits
);

  logic [63:0] res_r, res_nxt;
  logic        sign_r, sign_nxt;
  logic        special_r, special_nxt;
  logic        zero_r, zero_nxt;
  logic [54:0] mx_r, mx_nxt;
  logic [52:0] my_r, my_nxt;
  logic signed [12:0] ex_r, ex_nxt, ey_r, ey_nxt;

  logic [62:0] ax, ay;
  logic [55:0] diff;
  logic        ge;
  logic [11:0] sh;
  logic [52:0] shifted;

  assign ax = in_dividend_bits[62:0];
  assign ay = in_divisor_bits[62:0];
  assign diff = {1'b0, mx_r} - {3'b0, my_r};
  assign ge   = !diff[55];
  assign sh   = 12'(13'sd1 - ey_r);
  assign shifted = mx_r[52:0] >> sh[5:0];

  assign sts.special    = special_r;
  assign sts.norm_done  = mx_r[52] && my_r[52];
  assign sts.loop_done  = zero_r || (ex_r <= ey_r);
  assign sts.rnorm_done = zero_r || mx_r[52];
  assign out_remainder_bits = res_r;

  // Compute next register values per command
  always_comb begin
    res_nxt = res_r; sign_nxt = sign_r; special_nxt = special_r; zero_nxt = zero_r;
    mx_nxt = mx_r; my_nxt = my_r; ex_nxt = ex_r; ey_nxt = ey_r;
    if (cmd.load) begin
      sign_nxt    = in_dividend_bits[63];
      zero_nxt    = 1'b0;
      special_nxt = 1'b1;
      mx_nxt = {2'b0, (ax[62:52] != 0), ax[51:0]};
      my_nxt = {(ay[62:52] != 0), ay[51:0]};
      ex_nxt = (ax[62:52] != 0) ? $signed({2'b0, ax[62:52]}) : 13'sd1;
      ey_nxt = (ay[62:52] != 0) ? $signed({2'b0, ay[62:52]}) : 13'sd1;
      if ({1'b0, ax} > EXP_ALL)                 res_nxt = in_dividend_bits | QUIET_BIT;
      else if ({1'b0, ay} > EXP_ALL)            res_nxt = in_divisor_bits | QUIET_BIT;
      else if ({1'b0, ax} == EXP_ALL || ay == 0) res_nxt = DEFAULT_NAN;
      else if ({1'b0, ay} == EXP_ALL || ax == 0) res_nxt = in_dividend_bits;
      else if (ay > ax)                         res_nxt = in_dividend_bits;
      else if (ay == ax)                        res_nxt = in_dividend_bits & SIGN_BIT;
      else                                      special_nxt = 1'b0;
    end
    if (cmd.norm) begin
      if (!mx_r[52]) begin mx_nxt = mx_r << 1; ex_nxt = ex_r - 13'sd1; end
      if (!my_r[52]) begin my_nxt = my_r << 1; ey_nxt = ey_r - 13'sd1; end
    end
    if (cmd.step) begin
      if (ge) begin
        mx_nxt = {diff[53:0], 1'b0};
        if (diff[54:0] == 0) zero_nxt = 1'b1;
      end else begin
        mx_nxt = {mx_r[53:0], 1'b0};
      end
      ex_nxt = ex_r - 13'sd1;
    end
    if (cmd.fin && !zero_r) begin
      if (ge) mx_nxt = diff[54:0];
      if ((ge ? diff[54:0] : mx_r) == 0) zero_nxt = 1'b1;
    end
    if (cmd.rnorm) begin
      mx_nxt = mx_r << 1;
      ey_nxt = ey_r - 13'sd1;
    end
    if (cmd.pack) begin
      if (zero_r)             res_nxt = {sign_r, 63'b0};
      else if (ey_r > 0)      res_nxt = {sign_r, ey_r[10:0], mx_r[51:0]};
      else if (sh > 12'd63)   res_nxt = {sign_r, 63'b0};
      else                    res_nxt = {sign_r, 10'b0, shifted};
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt; sign_r <= sign_nxt; special_r <= special_nxt; zero_r <= zero_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
  end

endmodule

[rtl/float64_truncated_remainder_unit.sv]
// Channel  | Direction | Ports
// in       | input     | in_valid, in_stall, in_dividend_bits, in_divisor_bits
// out      | output    | out_valid, out_stall, out_remainder_bits
// One word at a time. Special cases go from load and classify straight to output; otherwise load, up to 52
// normalize steps, the shift-subtract loop with at most one step per unit of exponent difference,
// one final subtract, up to 52 remainder normalize steps, then output.
// Reset (rst_n low, synchronous) returns the controller to idle.
// A stalled result holds; no new word is taken until it is delivered.
// Depends on f64rem_pkg, f64rem_ctrl, f64rem_dp.
module float64_truncated_remainder_unit import f64rem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_dividend_bits,
  input  logic [63:0] in_divisor_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_remainder_bits
);

  f64rem_cmd_t cmd;
  f64rem_sts_t sts;

  f64rem_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  f64rem_dp u_dp (
    .clk, .in_dividend_bits, .in_divisor_bits, .cmd, .sts, .out_remainder_bits
  );

endmodule
